FILE: sv/cfc_pkg.sv
// Shared types, constants and helper functions of the candle flicker controller.
`timescale 1ns / 1ps

package cfc_pkg;

	// Ramp resolution: each LED moves in steps of one part in 2^RAMP_SHIFT
	localparam int RAMP_SHIFT = 3;

	localparam int LIGHT_W    = 12;
	localparam int LEVEL_W    = 8;
	localparam int COUNT_W    = 8;
	localparam int RAND_W     = 31;
	localparam int MOD_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);

	localparam logic [RAND_W-1:0]  LCG_MUL    = 31'd214013;
	localparam logic [RAND_W-1:0]  LCG_ADD    = 31'd2531011;
	localparam logic [MOD_W-1:0]   TARGET_MOD = 7'h7F;
	localparam logic [LEVEL_W-1:0] TARGET_MIN = 8'h80;
	localparam logic [COUNT_W-1:0] COUNT_SAT  = 8'd254;

	// Register reset values
	localparam logic [LIGHT_W-1:0] OFF_THR_RST = 12'd400;
	localparam logic [LIGHT_W-1:0] ON_THR_RST  = 12'd1200;
	localparam logic [COUNT_W-1:0] LIMIT_RST   = 8'd100;
	localparam logic [LEVEL_W-1:0] FLASH_RST   = 8'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_OFF  = 2'd0,
		REG_DARK_ON    = 2'd1,
		REG_BATT_LIMIT = 2'd2,
		REG_FLASH      = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_OFF     = 2'd0,
		CMD_FLASH   = 2'd1,
		CMD_FLICKER = 2'd2
	} cmd_kind_t;

	// One command from the front end to the sequencer
	typedef struct packed {
		cmd_kind_t          kind;
		logic               zero_levels;
		logic [LEVEL_W-1:0] flash;
		logic [LEVEL_W-1:0] target1;
		logic [LEVEL_W-1:0] target2;
	} cmd_t;

	// x mod 127 by folding 7-bit digits (127 = 2^7 - 1)
	function automatic logic [MOD_W-1:0] mod127(input logic [RAND_W-1:0] x);
		logic [9:0] s;
		logic [7:0] f;
		s = {3'b0, x[6:0]} + {3'b0, x[13:7]} + {3'b0, x[20:14]} + {3'b0, x[27:21]}
			+ {7'b0, x[30:28]};
		f = {1'b0, s[6:0]} + {5'b0, s[9:7]};
		if (f >= {1'b0, TARGET_MOD})
			f = f - {1'b0, TARGET_MOD};
		return f[MOD_W-1:0];
	endfunction

	// floor((target - level) / 2^RAMP_SHIFT) as an 8-bit two's complement step
	function automatic logic [LEVEL_W-1:0] ramp_step(input logic [LEVEL_W-1:0] target,
			input logic [LEVEL_W-1:0] level);
		logic signed [LEVEL_W:0] diff;
		logic signed [LEVEL_W:0] q;
		diff = signed'({1'b0, target}) - signed'({1'b0, level});
		q = diff >>> RAMP_SHIFT;
		return q[LEVEL_W-1:0];
	endfunction

endpackage

FILE: sv/cfc_if.sv
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface cfc_in_if;
	logic                        valid;
	logic                        ready;
	logic [cfc_pkg::LIGHT_W-1:0] light_count;
	logic                        battery_low;

	modport source (output valid, light_count, battery_low, input ready);
	modport sink (input valid, light_count, battery_low, output ready);
endinterface

interface cfc_out_if;
	logic                        valid;
	logic                        ready;
	logic [cfc_pkg::LEVEL_W-1:0] led1_level;
	logic [cfc_pkg::LEVEL_W-1:0] led2_level;
	logic                        leds_driven;
	logic                        last;

	modport source (output valid, led1_level, led2_level, leds_driven, last, input ready);
	modport sink (input valid, led1_level, led2_level, leds_driven, last, output ready);
endinterface

FILE: sv/cfc_front.sv
// Front end: registers, battery/lamp state, generator and command build.
`timescale 1ns / 1ps

module cfc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	cfc_in_if.sink                        in_ch,
	input  logic                          cfg_we,
	input  logic [cfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          q_full,
	output logic                          push,
	output cfc_pkg::cmd_t                 push_data
);

	// configuration registers
	logic [cfc_pkg::LIGHT_W-1:0] off_thr_q;
	logic [cfc_pkg::LIGHT_W-1:0] on_thr_q;
	logic [cfc_pkg::COUNT_W-1:0] limit_q;
	logic [cfc_pkg::LEVEL_W-1:0] flash_q;

	// loop state
	logic                         lamp_q;
	logic                         pwm_q;
	logic [cfc_pkg::COUNT_W-1:0]  batt_cnt_q;
	logic [cfc_pkg::RAND_W-1:0]   rand_q;
	logic [cfc_pkg::LEVEL_W-1:0]  prev_tgt_q;

	// stage 1: classified word plus new generator value
	logic                         v_s1;
	cfc_pkg::cmd_kind_t           kind_s1;
	logic                         zero_s1;
	logic [cfc_pkg::LEVEL_W-1:0]  flash_s1;
	logic [cfc_pkg::RAND_W-1:0]   rand_s1;

	// stage 2: finished command
	logic                         v_s2;
	cfc_pkg::cmd_t                cmd_s2;

	logic                         accept;
	logic                         adv_s1;
	logic                         en_s2;
	logic                         en_s1;
	logic [cfc_pkg::COUNT_W-1:0]  batt_nxt;
	logic                         lamp_nxt;
	cfc_pkg::cmd_kind_t           kind_nxt;
	logic [cfc_pkg::RAND_W-1:0]   seed;
	logic [cfc_pkg::RAND_W-1:0]   rand_nxt;
	logic [cfc_pkg::LEVEL_W-1:0]  tgt1;

	// pipeline flow control
	assign push        = v_s2 && !q_full;
	assign en_s2       = !v_s2 || !q_full;
	assign adv_s1      = v_s1 && en_s2;
	assign en_s1       = !v_s1 || en_s2;
	assign in_ch.ready = en_s1;
	assign accept      = in_ch.valid && en_s1;
	assign push_data   = cmd_s2;

	// classify the pass
	always_comb begin
		if (!in_ch.battery_low)
			batt_nxt = '0;
		else if (batt_cnt_q >= cfc_pkg::COUNT_SAT)
			batt_nxt = cfc_pkg::COUNT_SAT;
		else
			batt_nxt = batt_cnt_q + 1'b1;

		if (in_ch.light_count <= off_thr_q)
			lamp_nxt = 1'b0;
		else if (in_ch.light_count >= on_thr_q)
			lamp_nxt = 1'b1;
		else
			lamp_nxt = lamp_q;

		if (!lamp_nxt)
			kind_nxt = cfc_pkg::CMD_OFF;
		else if (batt_nxt > limit_q)
			kind_nxt = cfc_pkg::CMD_FLASH;
		else
			kind_nxt = cfc_pkg::CMD_FLICKER;

		// reseed from the light count when the PWM was stopped
		seed     = pwm_q ? rand_q : {{(cfc_pkg::RAND_W - cfc_pkg::LIGHT_W){1'b0}},
			in_ch.light_count};
		rand_nxt = seed * cfc_pkg::LCG_MUL + cfc_pkg::LCG_ADD;
	end

	assign tgt1 = {1'b0, cfc_pkg::mod127(rand_s1)} | cfc_pkg::TARGET_MIN;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_thr_q <= cfc_pkg::OFF_THR_RST;
			on_thr_q  <= cfc_pkg::ON_THR_RST;
			limit_q   <= cfc_pkg::LIMIT_RST;
			flash_q   <= cfc_pkg::FLASH_RST;
		end else if (cfg_we) begin
			unique case (cfc_pkg::cfg_reg_t'(cfg_index))
				cfc_pkg::REG_LIGHT_OFF:  off_thr_q <= cfg_wdata;
				cfc_pkg::REG_DARK_ON:    on_thr_q  <= cfg_wdata;
				cfc_pkg::REG_BATT_LIMIT: limit_q   <= cfg_wdata[cfc_pkg::COUNT_W-1:0];
				cfc_pkg::REG_FLASH:      flash_q   <= cfg_wdata[cfc_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// loop state, updated as each word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q     <= 1'b0;
			pwm_q      <= 1'b0;
			batt_cnt_q <= '0;
			rand_q     <= '0;
		end else if (accept) begin
			lamp_q     <= lamp_nxt;
			batt_cnt_q <= batt_nxt;
			pwm_q      <= (kind_nxt == cfc_pkg::CMD_FLICKER);
			if (kind_nxt == cfc_pkg::CMD_FLICKER)
				rand_q <= rand_nxt;
			else if (kind_nxt == cfc_pkg::CMD_FLASH)
				rand_q <= seed;
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_s1)
			v_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_nxt;
			zero_s1  <= lamp_nxt && !pwm_q;
			flash_s1 <= flash_q;
			rand_s1  <= rand_nxt;
		end
	end

	// stage 2 register; LED2 takes the previous LED1 target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			prev_tgt_q <= '0;
		end else begin
			if (en_s2)
				v_s2 <= v_s1;
			if (adv_s1 && kind_s1 == cfc_pkg::CMD_FLICKER)
				prev_tgt_q <= tgt1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s2.kind        <= kind_s1;
			cmd_s2.zero_levels <= zero_s1;
			cmd_s2.flash       <= flash_s1;
			cmd_s2.target1     <= tgt1;
			cmd_s2.target2     <= prev_tgt_q;
		end
	end

endmodule

FILE: sv/cfc_queue.sv
// Four-entry command queue between the front end and the sequencer.
`timescale 1ns / 1ps

module cfc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cfc_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output cfc_pkg::cmd_t pop_data,
	output logic          empty
);

	cfc_pkg::cmd_t                mem [cfc_pkg::Q_DEPTH];
	logic [cfc_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [cfc_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [cfc_pkg::Q_PTR_W:0]    count_q;

	assign full     = (count_q == (cfc_pkg::Q_PTR_W+1)'(cfc_pkg::Q_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
`endif

endmodule

FILE: sv/cfc_back.sv
// Sequencer: turns commands into LED words, one word per cycle while the output is not stalled.
`timescale 1ns / 1ps

module cfc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  cfc_pkg::cmd_t q_data,
	output logic          pop,
	cfc_out_if.source     out_ch
);

	localparam int CNT_W = cfc_pkg::RAMP_SHIFT;

	cfc_pkg::cmd_t                cur_q;
	logic                         busy_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [cfc_pkg::LEVEL_W-1:0]  lvl1_q;
	logic [cfc_pkg::LEVEL_W-1:0]  lvl2_q;
	logic [cfc_pkg::LEVEL_W-1:0]  step1_q;
	logic [cfc_pkg::LEVEL_W-1:0]  step2_q;

	logic                         out_v_q;
	logic [cfc_pkg::LEVEL_W-1:0]  out_l1_q;
	logic [cfc_pkg::LEVEL_W-1:0]  out_l2_q;
	logic                         out_drv_q;
	logic                         out_last_q;

	logic                         out_space;
	logic                         emit;
	logic                         last_w;
	logic [cfc_pkg::LEVEL_W-1:0]  w_l1;
	logic [cfc_pkg::LEVEL_W-1:0]  w_l2;
	logic                         w_drv;
	logic [cfc_pkg::LEVEL_W-1:0]  sum1;
	logic [cfc_pkg::LEVEL_W-1:0]  sum2;
	logic [cfc_pkg::LEVEL_W-1:0]  fwd1;
	logic [cfc_pkg::LEVEL_W-1:0]  fwd2;
	logic [cfc_pkg::LEVEL_W-1:0]  base1;
	logic [cfc_pkg::LEVEL_W-1:0]  base2;

	assign out_space = !out_v_q || out_ch.ready;
	assign emit      = busy_q && out_space;
	assign sum1      = lvl1_q + step1_q;
	assign sum2      = lvl2_q + step2_q;

	// word of the current command at the current step
	always_comb begin
		w_l1   = '0;
		w_l2   = '0;
		w_drv  = 1'b0;
		last_w = 1'b1;
		case (cur_q.kind)
			cfc_pkg::CMD_FLASH: begin
				if (cnt_q == '0) begin
					w_l1   = lvl1_q;
					w_l2   = lvl2_q;
					w_drv  = 1'b1;
					last_w = 1'b0;
				end
			end
			cfc_pkg::CMD_FLICKER: begin
				w_drv = 1'b1;
				if (cnt_q == '1) begin
					w_l1 = cur_q.target1;
					w_l2 = cur_q.target2;
				end else begin
					w_l1   = sum1;
					w_l2   = sum2;
					last_w = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// next command may start on the cycle the current one ends
	assign pop = !q_empty && (!busy_q || (emit && last_w));

	// levels left by the current command, forwarded to the next one
	always_comb begin
		if (busy_q && cur_q.kind == cfc_pkg::CMD_FLICKER) begin
			fwd1 = cur_q.target1;
			fwd2 = cur_q.target2;
		end else begin
			fwd1 = lvl1_q;
			fwd2 = lvl2_q;
		end
		base1 = q_data.zero_levels ? '0 : fwd1;
		base2 = q_data.zero_levels ? '0 : fwd2;
	end

	// sequencer control and levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			lvl1_q <= '0;
			lvl2_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			lvl2_q <= base2;
			if (q_data.kind == cfc_pkg::CMD_FLASH)
				lvl1_q <= q_data.flash;
			else
				lvl1_q <= base1;
		end else if (emit) begin
			if (last_w)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + 1'b1;
			if (cur_q.kind == cfc_pkg::CMD_FLICKER) begin
				lvl1_q <= w_l1;
				lvl2_q <= w_l2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q   <= q_data;
			step1_q <= cfc_pkg::ramp_step(q_data.target1, base1);
			step2_q <= cfc_pkg::ramp_step(q_data.target2, base2);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_space)
			out_v_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_l1_q   <= w_l1;
			out_l2_q   <= w_l2;
			out_drv_q  <= w_drv;
			out_last_q <= last_w;
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.led1_level  = out_l1_q;
	assign out_ch.led2_level  = out_l2_q;
	assign out_ch.leds_driven = out_drv_q;
	assign out_ch.last        = out_last_q;

`ifndef ASSERT_OFF
	a_undriven_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_drv_q) |-> (out_last_q && out_l1_q == '0 && out_l2_q == '0))
		else $error("undriven word must be a zeroed final word");
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_w && !pop) |=> !busy_q)
		else $error("sequencer still busy after final word");
	a_flicker_count: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !last_w && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("ramp step counter skipped");
`endif

endmodule

FILE: sv/candle_flicker_controller.sv
// Top level of the candle flicker controller: front end, queue and sequencer.
`timescale 1ns / 1ps

// Usage:
//   in_ch takes one word per control-loop pass: light_count and battery_low.
//   out_ch gives the LED words of that pass, the final one flagged by last:
//   one word when the lamp is off, two for a low-battery flash, and
//   2^RAMP_SHIFT (8) ramp words while flickering.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (0 light-off
//   threshold, 1 dark-on threshold, 2 battery-low limit, 3 flash level);
//   write only while no pass is in flight.
//   The input word of a pass goes through two front-end stages, the queue,
//   the sequencer and the output register before its first word is valid.
//   Throughput: the sequencer emits one word per cycle while out_ch is not
//   stalled; the front end takes a word every cycle until the four-entry
//   command queue fills.
//   Reset (arst_n low) restores register defaults, turns the lamp off, clears
//   the generator and empties the pipeline; no clearing pass is needed.
//   When the receiver stalls, the output register holds its word, the
//   sequencer waits, the queue fills, and then in_ch.ready falls.

module candle_flicker_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	cfc_in_if.sink                         in_ch,
	cfc_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	cfc_pkg::cmd_t push_data;
	cfc_pkg::cmd_t pop_data;

	cfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	cfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	cfc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule
